// ----- design/artu_pkg.sv -----
// Package for the acceleration run timer: payload, configuration and state types,
// mark codes and register indexes. No dependencies; every other file but artu_stream_if imports it.
`default_nettype none

package artu_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned SpeedW = 12;
    localparam int unsigned HoldW  = 20;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = HoldW;

    // Mark codes, as carried in which_mark.
    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_LOW  = 2'd1,
        MARK_HIGH = 2'd2
    } t_mark;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_STOP_SPEED = 2'd0,
        CFG_LOW_MARK   = 2'd1,
        CFG_HIGH_MARK  = 2'd2,
        CFG_HOLD_TIME  = 2'd3
    } t_cfg_idx;

    localparam logic [SpeedW-1:0] StopSpeedReset = SpeedW'(10);
    localparam logic [SpeedW-1:0] LowMarkReset   = SpeedW'(500);
    localparam logic [SpeedW-1:0] HighMarkReset  = SpeedW'(1000);
    localparam logic [HoldW-1:0]  HoldTimeReset  = HoldW'(7000);

    typedef struct packed {
        logic [TimeW-1:0]  now_ms;
        logic [SpeedW-1:0] speed;
        logic              in_drive;
    } t_sample;

    typedef struct packed {
        logic             display_active;
        logic [1:0]       which_mark;
        logic [TimeW-1:0] run_ms;
    } t_result;

    typedef struct packed {
        logic [SpeedW-1:0] stop_speed;
        logic [SpeedW-1:0] low_mark;
        logic [SpeedW-1:0] high_mark;
        logic [HoldW-1:0]  hold_time_ms;
    } t_cfg;

    typedef struct packed {
        logic             running;
        logic [TimeW-1:0] start_time;
        logic             got_low;
        logic             got_high;
        t_mark            shown_mark;
        logic [TimeW-1:0] shown_elapsed;
        logic [TimeW-1:0] shown_time;
    } t_state;

endpackage

`default_nettype wire

// ----- design/artu_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat of a given type.
// Depends on nothing; the payload type comes in as a parameter.
`default_nettype none

interface artu_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/artu_step.sv -----
// Combinational update of the timer state for one sample and the display it yields.
// Depends on artu_pkg.
`default_nettype none

module artu_step (
    input  artu_pkg::t_cfg    i_cfg,
    input  artu_pkg::t_state  i_state,
    input  artu_pkg::t_sample i_sample,
    output artu_pkg::t_state  o_state,
    output artu_pkg::t_result o_result
);
    import artu_pkg::*;

    logic             low_hit;
    logic             high_hit;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] age;
    logic             active;

    assign elapsed = i_sample.now_ms - i_state.start_time;

    always_comb begin
        o_state  = i_state;
        low_hit  = 1'b0;
        high_hit = 1'b0;
        if (i_sample.speed < i_cfg.stop_speed) begin
            o_state.running  = 1'b0;
            o_state.got_low  = 1'b0;
            o_state.got_high = 1'b0;
        end else if (!i_state.running) begin
            if (i_sample.in_drive) begin
                o_state.running    = 1'b1;
                o_state.start_time = i_sample.now_ms;
                o_state.got_low    = 1'b0;
                o_state.got_high   = 1'b0;
            end
        end else if (!i_sample.in_drive) begin
            o_state.running = 1'b0;
        end else begin
            low_hit  = !i_state.got_low  && (i_sample.speed >= i_cfg.low_mark);
            high_hit = !i_state.got_high && (i_sample.speed >= i_cfg.high_mark);
            if (low_hit) begin
                o_state.got_low       = 1'b1;
                o_state.shown_mark    = MARK_LOW;
                o_state.shown_elapsed = elapsed;
                o_state.shown_time    = i_sample.now_ms;
            end
            // The high mark is latched after the low one, so it wins a shared sample.
            if (high_hit) begin
                o_state.got_high      = 1'b1;
                o_state.running       = 1'b0;
                o_state.shown_mark    = MARK_HIGH;
                o_state.shown_elapsed = elapsed;
                o_state.shown_time    = i_sample.now_ms;
            end
        end
    end

    // Age of the latched result, modulo 2^32, against the 20-bit hold time.
    assign age    = i_sample.now_ms - o_state.shown_time;
    assign active = (o_state.shown_mark != MARK_NONE)
                    && (age[TimeW-1:HoldW] == '0)
                    && (age[HoldW-1:0] <= i_cfg.hold_time_ms);

    always_comb begin
        o_result.display_active = active;
        o_result.which_mark     = active ? o_state.shown_mark : MARK_NONE;
        o_result.run_ms         = active ? o_state.shown_elapsed : '0;
    end

endmodule

`default_nettype wire

// ----- design/acceleration_run_timer_unit.sv -----
// Top level of the acceleration run timer: input register, state registers and
// result register around artu_step. Depends on artu_pkg, artu_stream_if, artu_step.
//
//   Channel    Direction  Beat contents
//   i_sample   in         now_ms[31:0], speed[11:0], in_drive
//   o_result   out        display_active, which_mark[1:0], run_ms[31:0]
//   i_cfg_*    in         write enable, index[1:0], data[19:0] (no handshake)
//
// One sample is accepted every cycle when the result side keeps up. A sample
// is held in the input register and its result is then written into the result
// register, from which it is presented on o_result. The timer state is updated
// in the same cycle that writes the result register. When the result is not
// taken, the result register holds; an empty input register takes one more beat,
// then ready drops. Reset is synchronous and active low; it empties both
// stages, clears the timer state and loads the register defaults.
`default_nettype none

module acceleration_run_timer_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    artu_stream_if.sink                    i_sample,
    artu_stream_if.source                  o_result,
    input  wire                            i_cfg_we,
    input  wire [artu_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  wire [artu_pkg::CfgDataW-1:0]   i_cfg_data
);
    import artu_pkg::*;

    // Input register stage.
    logic    r_s1_valid;
    t_sample r_s1_data;

    // Result register stage.
    logic    r_out_valid;
    t_result r_out_data;

    // Timer state and configuration.
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_cfg    r_cfg;

    logic advance;
    logic in_take;

    // The result register can take a new beat when it is empty or being drained.
    assign advance  = !r_out_valid || o_result.ready;
    assign in_take  = i_sample.valid && i_sample.ready;

    assign i_sample.ready = !r_s1_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    artu_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_sample (r_s1_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_s1_valid <= i_sample.valid;
        end
        if (in_take) begin
            r_s1_data <= i_sample.data;
        end
    end

    // The state moves only when the buffered sample passes into the result register,
    // so each sample updates it exactly once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{
                running:       1'b0,
                start_time:    '0,
                got_low:       1'b0,
                got_high:      1'b0,
                shown_mark:    MARK_NONE,
                shown_elapsed: '0,
                shown_time:    '0
            };
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_s1_valid) begin
            r_out_data <= n_result;
        end
    end

    // Configuration registers; the user must write them only while no beat is in flight (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_speed   <= StopSpeedReset;
            r_cfg.low_mark     <= LowMarkReset;
            r_cfg.high_mark    <= HighMarkReset;
            r_cfg.hold_time_ms <= HoldTimeReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STOP_SPEED: r_cfg.stop_speed   <= i_cfg_data[SpeedW-1:0];
                CFG_LOW_MARK:   r_cfg.low_mark     <= i_cfg_data[SpeedW-1:0];
                CFG_HIGH_MARK:  r_cfg.high_mark    <= i_cfg_data[SpeedW-1:0];
                CFG_HOLD_TIME:  r_cfg.hold_time_ms <= i_cfg_data[HoldW-1:0];
                default:        r_cfg              <= r_cfg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/artu_checker.sv -----
// Port-level assertions for the acceleration run timer and their bind to the top.
// Depends on artu_pkg and acceleration_run_timer_unit.
`default_nettype none

module artu_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        i_in_ready,
    input wire                        i_out_valid,
    input wire                        i_out_ready,
    input wire                        i_out_active,
    input wire [1:0]                  i_out_mark,
    input wire [artu_pkg::TimeW-1:0]  i_out_run_ms
);
    import artu_pkg::*;

    // An inactive display carries no mark and no time.
    a_idle_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_active) |-> (i_out_mark == MARK_NONE && i_out_run_ms == '0))
        else $error("inactive result carries a mark or time");

    // An active display always names the low or the high mark.
    a_active_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_active) |-> (i_out_mark == MARK_LOW || i_out_mark == MARK_HIGH))
        else $error("active result without a valid mark");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_active) && $stable(i_out_mark)
             && $stable(i_out_run_ms)))
        else $error("stalled result beat changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // An accepted sample with a free output side passes the input register and shows up as a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (!i_out_valid || i_out_ready)) |=> ##1
            ($past(i_rst_n) ? i_out_valid || !$past(i_out_valid || i_out_ready) : 1'b1))
        else $error("accepted sample produced no result");

endmodule

bind acceleration_run_timer_unit artu_checker u_artu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample.valid),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_active (o_result.data.display_active),
    .i_out_mark   (o_result.data.which_mark),
    .i_out_run_ms (o_result.data.run_ms)
);

`default_nettype wire
